/* rtl/mwsl_pkg.sv */
// ----------------------------------------------------------------------------
// mwsl_pkg
// Shared widths, register map and helpers for the minimum window sum length
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsl_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int VALUE_BITS = 16;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 26;
  localparam int THR_W = 26;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Word index of each configuration register (paddr[2]).
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1);

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx);
    logic [PTR_W-1:0] res;
    if (idx == PTR_W'(MAX_WINDOW - 1)) begin
      res = '0;
    end else begin
      res = idx + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/mwsl_if.sv */
// ----------------------------------------------------------------------------
// mwsl_item_if / mwsl_result_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwsl_item_if
  import mwsl_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface mwsl_result_if
  import mwsl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] best_length;
  logic             overflow;
  logic             sequence_done;

  modport source (output valid, output best_length, output overflow,
                  output sequence_done, input ready);
  modport sink   (input valid, input best_length, input overflow,
                  input sequence_done, output ready);
endinterface

`default_nettype wire

/* rtl/min_window_sum_length.sv */
// ----------------------------------------------------------------------------
// min_window_sum_length
// Streaming tracker of the shortest contiguous run whose sum reaches a
// programmable threshold.
// ----------------------------------------------------------------------------
// Values of one sequence arrive on the item channel and each one produces a
// single result: the shortest window length found so far (0 while none has
// reached the threshold), a sticky overflow flag and a copy of last_item. The
// live window is kept in a 1024 x 16 single-port-read synchronous RAM used as
// a circular buffer; the running sum, indices and count live in registers.
// An item passes through accept, push and a final check, plus a check and
// a removal step for every oldest value that is removed while the sum still
// meets the threshold, because each removal needs a registered RAM read
// before the value can be subtracted. Every value is removed at most once.
// A new item is taken only once the previous one has produced its result,
// but the result sits in an output register so the block can take the next
// item while the consumer has not yet taken it. The RAM needs no clearing
// pass: only entries inside the live window are read. A transfer flagged
// last_item clears the sequence state after its result is formed; the
// threshold is kept. The threshold is register 0 of the APB port (byte
// address 0) and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module min_window_sum_length
  import mwsl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  mwsl_item_if.sink              item,
  mwsl_result_if.source          result
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUSH  = 4'b0010,
    S_CHECK = 4'b0100,
    S_POP   = 4'b1000
  } state_t;

  logic [THR_W-1:0] threshold;

  mwsl_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  // Window store. The read port always looks at the oldest entry; its data
  // is registered and consumed in the cycle after the address was presented.
  logic [VALUE_BITS-1:0] window_mem [MAX_WINDOW];
  logic [VALUE_BITS-1:0] rdata;

  state_t                state, state_next;
  logic [PTR_W-1:0]      head, head_next;
  logic [PTR_W-1:0]      tail, tail_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [SUM_W-1:0]      sum, sum_next;
  logic [CNT_W-1:0]      best, best_next;
  logic                  overflow_seen, overflow_seen_next;
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;

  logic accept;
  logic full;
  logic qualifies;
  logic out_free;
  logic finish;
  logic mem_we;

  assign accept    = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign full      = (count == CNT_W'(MAX_WINDOW));
  assign qualifies = (count != '0) && (sum >= SUM_W'(threshold));
  assign out_free  = !result.valid || result.ready;
  assign finish    = (state == S_CHECK) && !qualifies && out_free;
  assign mem_we    = (state == S_PUSH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[head] <= value_q;
    end
    rdata <= window_mem[tail];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q <= item.value;
      last_q  <= item.last_item;
    end
  end

  always_comb begin
    state_next         = state;
    head_next          = head;
    tail_next          = tail;
    count_next         = count;
    sum_next           = sum;
    best_next          = best;
    overflow_seen_next = overflow_seen;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        // A full window first drops its oldest value, read during accept.
        if (full) begin
          tail_next          = advance(tail);
          overflow_seen_next = 1'b1;
          sum_next           = sum - SUM_W'(rdata) + SUM_W'(value_q);
        end else begin
          count_next = count + CNT_W'(1);
          sum_next   = sum + SUM_W'(value_q);
        end
        head_next  = advance(head);
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (qualifies) begin
          if (best == '0 || count < best) begin
            best_next = count;
          end
          state_next = S_POP;
        end else if (out_free) begin
          state_next = S_IDLE;
          if (last_q) begin
            head_next          = '0;
            tail_next          = '0;
            count_next         = '0;
            sum_next           = '0;
            best_next          = '0;
            overflow_seen_next = 1'b0;
          end
        end
      end
      S_POP: begin
        sum_next   = sum - SUM_W'(rdata);
        tail_next  = advance(tail);
        count_next = count - CNT_W'(1);
        state_next = S_CHECK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      sum           <= '0;
      best          <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      count         <= count_next;
      sum           <= sum_next;
      best          <= best_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Output register: loaded when an item finishes, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.best_length   <= best;
      result.overflow      <= overflow_seen;
      result.sequence_done <= last_q;
    end
  end

`ifndef NO_ASSERTIONS
  // The window never holds more values than the store has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WINDOW))
    else $error("window count above capacity");

  // An accepted transfer always moves on to the push step.
  a_accept_push: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PUSH)
    else $error("accepted item did not reach push");

  // A removal only happens on a non-empty window and shortens it by one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> count != '0 ##1 (count + CNT_W'(1)) == $past(count))
    else $error("pop step count mismatch");

  // A new result only appears at the end of the check loop.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_CHECK)
    else $error("result raised outside the check step");
`endif

endmodule

`default_nettype wire

/* rtl/mwsl_apb.sv */
// ----------------------------------------------------------------------------
// mwsl_apb
// APB register block holding the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsl_apb
  import mwsl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [THR_W-1:0]  threshold
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (wr_en && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESHOLD) begin
      prdata = DATA_W'(threshold);
    end
  end

endmodule

`default_nettype wire

/* tb/mwsl_checker.sv */
// ----------------------------------------------------------------------------
// mwsl_checker
// Watches the item, result and APB channels of the minimum window sum length
// tracker, predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------

module mwsl_checker
  import mwsl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic              pready,
  mwsl_item_if                   item,
  mwsl_result_if                 result,
  output int unsigned            failures,
  output int unsigned            outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CNT_W-1:0] best_length;
    logic             overflow;
    logic             sequence_done;
  } window_outcome_t;

  // Shadow copy of the window and of the threshold register.
  logic [VALUE_BITS-1:0] win_mem [MAX_WINDOW];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      win_count;
  logic [SUM_W:0]        win_sum;
  logic [CNT_W-1:0]      best_len;
  logic                  ovf_seen;
  logic [THR_W-1:0]      threshold;

  window_outcome_t outcomes_q[$];
  int unsigned     mismatch_count;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  task automatic clear_window();
    wr_ptr    = '0;
    rd_ptr    = '0;
    win_count = '0;
    win_sum   = '0;
    best_len  = '0;
    ovf_seen  = 1'b0;
  endtask

  task automatic drop_oldest();
    win_sum   = win_sum - win_mem[rd_ptr];
    rd_ptr    = next_slot(rd_ptr);
    win_count = win_count - 1'b1;
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t mwsl_checker: %s", $time, msg);
    end
  endtask

  // Appends one value, shrinks the window while it still meets the threshold
  // and queues the outcome the block has to report for it.
  task automatic slide_window(input logic [VALUE_BITS-1:0] v, input logic last);
    window_outcome_t o;
    if (win_count == CNT_W'(MAX_WINDOW)) begin
      drop_oldest();
      ovf_seen = 1'b1;
    end
    win_mem[wr_ptr] = v;
    wr_ptr    = next_slot(wr_ptr);
    win_count = win_count + 1'b1;
    win_sum   = win_sum + v;
    while (win_count != 0 && win_sum >= {1'b0, threshold}) begin
      if (best_len == 0 || win_count < best_len) begin
        best_len = win_count;
      end
      drop_oldest();
    end
    o.best_length   = best_len;
    o.overflow      = ovf_seen;
    o.sequence_done = last;
    outcomes_q.push_back(o);
    if (last) begin
      clear_window();
    end
  endtask

  task automatic check_result();
    window_outcome_t exp;
    if (outcomes_q.size() == 0) begin
      note_failure($sformatf("result with nothing pending: best_length %0d overflow %0b done %0b",
                             result.best_length, result.overflow, result.sequence_done));
    end else begin
      exp = outcomes_q.pop_front();
      if (result.best_length !== exp.best_length || result.overflow !== exp.overflow ||
          result.sequence_done !== exp.sequence_done) begin
        note_failure($sformatf({"result mismatch: best_length %0d/%0d overflow %0b/%0b ",
                                "done %0b/%0b (expected/actual)"},
                               exp.best_length, result.best_length, exp.overflow,
                               result.overflow, exp.sequence_done, result.sequence_done));
      end
    end
  endtask

  // Results are compared before the item of the same edge is absorbed, since
  // a result can never belong to an item accepted at that very edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_window();
      threshold = THRESHOLD_RESET;
      outcomes_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        check_result();
      end
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_THRESHOLD) begin
        threshold = pwdata[THR_W-1:0];
      end
      if (item.valid && item.ready) begin
        slide_window(item.value, item.last_item);
      end
    end
    failures    <= mismatch_count;
    outstanding <= outcomes_q.size();
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the minimum window sum length tracker.
// ----------------------------------------------------------------------------
// Streams sequences of 16-bit values into the block, programs the threshold
// over APB between phases, and leaves prediction and comparison to
// mwsl_checker. A directed opening walks the value extremes, single-item
// sequences, the smallest, largest and zero thresholds; one long sequence
// overruns the 1024-entry window; then random sequences run under random
// thresholds. Both channels idle at random, and the receiver holds off for
// long stretches so the block backs up into its input.
// ----------------------------------------------------------------------------

module tb_top
  import mwsl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Values pushed in the random part, overflow sequence excluded.
  localparam int unsigned RANDOM_ITEMS = 950;
  // Lengths of the overflow sequence's parts: a window-filling stretch of small
  // values, then a run of large ones that finally reaches the threshold.
  localparam int unsigned FILL_ITEMS   = 1030;
  localparam int unsigned BURST_ITEMS  = 30;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_SETTLE  = 8;
  // One value may empty a full window, one removal at a time, and the
  // receiver may hold off for HOLD_CYCLES on top; this is many times both.
  localparam int unsigned STALL_LIMIT  = 20000;

  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef enum logic [1:0] {MIX_FULL, MIX_NARROW, MIX_SPARSE, MIX_CORNER} value_mix_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned sequences_sent;
  int unsigned cfg_writes;
  int unsigned chk_failures;
  int unsigned chk_pending;

  mwsl_item_if   item_ch();
  mwsl_result_if result_ch();

  min_window_sum_length i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  mwsl_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .item        (item_ch),
    .result      (result_ch),
    .failures    (chk_failures),
    .outstanding (chk_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_BITS-1:0] draw_value(input value_mix_t mix);
    case (mix)
      MIX_NARROW: return VALUE_BITS'($urandom_range(0, 255));
      MIX_SPARSE: return ($urandom_range(0, 3) == 0) ? VALUE_BITS'($urandom) : '0;
      MIX_CORNER: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return VALUE_BITS'(1);
          3: return VALUE_BITS'(1) << (VALUE_BITS - 1);
          default: return VALUE_BITS'($urandom);
        endcase
      end
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Thresholds spread over the whole register range, weighted toward sizes
  // that give windows of a handful to a few hundred values. Zero is still a
  // legal register value.
  function automatic logic [THR_W-1:0] draw_threshold();
    case ($urandom_range(0, 9))
      0: return THR_W'(1);
      1: return THR_MAX;
      2: return THR_W'($urandom_range(2, 300));
      3, 4: return THR_W'($urandom_range(300, 70000));
      5, 6: return THR_W'($urandom_range(70000, 600000));
      7: return THR_W'($urandom_range(600000, THR_MAX));
      8: return THR_W'(65536);
      default: return ($urandom_range(0, 2) == 0) ? '0 : THR_W'(65535);
    endcase
  endfunction

  // Offers one value and returns at the edge of its transfer. With no gap
  // valid is left high, so the next call simply replaces the payload.
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic last,
                            input bit steady);
    int unsigned gap;
    item_ch.valid     <= 1'b1;
    item_ch.value     <= v;
    item_ch.last_item <= last;
    @(posedge clk);
    while (!item_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
    if (last) begin
      sequences_sent++;
    end
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every value yields exactly one result, so the block is idle once the
  // result count catches up with the value count.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (results_seen != items_sent) begin
      @(posedge clk);
    end
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge that ends the access with pready high.
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= DATA_W'(thr);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  // Receiver: random stalls, calm stretches with ready held high, and a long
  // hold-off at 300 results and every 1200 on, so the output register fills
  // and the block stops taking values while the sender keeps offering.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned steady_left;
    int unsigned hold_mark;
    stall_left  = 0;
    steady_left = 0;
    hold_mark   = 300;
    results_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
      end
      if (!rst && results_seen >= hold_mark) begin
        stall_left = HOLD_CYCLES;
        hold_mark += 1200;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (steady_left > 0) begin
          steady_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          steady_left = $urandom_range(100, 300);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned len;
    int unsigned phase_seqs;
    value_mix_t  mix;
    bit          steady;

    items_sent     = 0;
    sequences_sent = 0;
    cfg_writes     = 0;
    random_items   = 0;
    phase_seqs     = 0;

    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.value     <= '0;
    item_ch.last_item <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Threshold still at its reset value of 1: zeros never qualify, and any
    // nonzero value is a window of one. The second sequence is a single
    // value flagged last, right after another last.
    send_value('0, 1'b0, 1'b0);
    send_value('0, 1'b0, 1'b0);
    send_value('1, 1'b1, 1'b0);
    send_value(VALUE_BITS'(1), 1'b1, 1'b0);

    // A small threshold where the window first reaches it at length three
    // and the best length then shrinks as later values arrive, down to one.
    wait_idle();
    write_threshold(THR_W'(100));
    send_value(VALUE_BITS'(40), 1'b0, 1'b0);
    send_value(VALUE_BITS'(30), 1'b0, 1'b0);
    send_value(VALUE_BITS'(50), 1'b0, 1'b0);
    send_value(VALUE_BITS'(20), 1'b0, 1'b0);
    send_value(VALUE_BITS'(10), 1'b0, 1'b0);
    send_value(16'h5555, 1'b1, 1'b0);

    // Largest threshold: out of reach for any short run.
    wait_idle();
    write_threshold(THR_MAX);
    send_value('1, 1'b0, 1'b0);
    send_value(16'hAAAA, 1'b1, 1'b0);

    // Zero threshold: every window qualifies, including one holding a zero,
    // so the window empties after each value and the best length is 1.
    wait_idle();
    write_threshold('0);
    send_value('0, 1'b0, 1'b0);
    send_value(16'h5555, 1'b1, 1'b0);

    // Overflow: small values keep the window sum below the threshold until
    // it holds 1024 values, so the oldest ones start to drop and the flag
    // sets. Large values then push the sum over and a length is found with
    // the flag still raised. The sequence after it must see both cleared.
    wait_idle();
    write_threshold(THR_W'(1500000));
    for (int unsigned n = 0; n < FILL_ITEMS + BURST_ITEMS; n++) begin
      if (n < FILL_ITEMS) begin
        send_value(VALUE_BITS'($urandom_range(0, 1000)), 1'b0, 1'b0);
      end else begin
        send_value(VALUE_BITS'($urandom_range(60000, 65535)),
                   n == FILL_ITEMS + BURST_ITEMS - 1, 1'b0);
      end
    end

    // Random sequences, a new threshold every few of them. Most are short;
    // one in ten is long enough to hold a deep window. One in five goes out
    // back to back so the block sees no gaps on its input.
    while (random_items < RANDOM_ITEMS) begin
      if (phase_seqs == 0) begin
        wait_idle();
        write_threshold(draw_threshold());
        phase_seqs = $urandom_range(3, 8);
      end
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      mix    = value_mix_t'($urandom_range(0, 3));
      steady = ($urandom_range(0, 4) == 0);
      for (int unsigned n = 0; n < len; n++) begin
        send_value(draw_value(mix), n == len - 1, steady);
      end
      random_items += len;
      phase_seqs--;
    end

    wait_idle();
    $display("tb_top: %0d values in %0d sequences under %0d threshold writes, %0d results",
             items_sent, sequences_sent, cfg_writes, results_seen);
    $display("tb_top: %0d failed results, %0d results never returned",
             chk_failures, chk_pending);
    if (chk_failures == 0 && chk_pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mwsl_pkg.sv
rtl/mwsl_if.sv
rtl/mwsl_apb.sv
rtl/min_window_sum_length.sv
tb/mwsl_checker.sv
tb/tb_top.sv
